// File: hdl/ico_pkg.sv
`default_nettype none
package ico_pkg;

  localparam int FRAC = 15;
  localparam int CW = FRAC + 2;
  localparam int STEPS_PER_LEVEL = 40;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CELLS = CORDIC_STEPS + 1;

  // step layout inside one level
  localparam int ST_MAG = 0;
  localparam int ST_SQR = 1;
  localparam int ST_ROOT0 = 2;
  localparam int ROOT_STEPS = 18;
  localparam int ST_DIVINIT = ST_ROOT0 + ROOT_STEPS;
  localparam int ST_DIV0 = ST_DIVINIT + 1;
  localparam int QBITS = 18;
  localparam int ST_FIN = ST_DIV0 + QBITS;

  localparam int SEED_S = 17227;
  localparam int SEED_L = 27874;
  localparam int ONE = 32768;

  localparam logic signed [27:0] PI_ANG = 28'sd16777216;
  localparam logic signed [17:0] V_HIGH = 18'sd13107;
  localparam logic signed [17:0] V_LOW = 18'sd3276;
  localparam logic signed [17:0] V_TURN = 18'sd16384;

  localparam logic [2:0] REG_LEVEL = 3'd0;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [2:0] vec_t;

  localparam int SEEDS [12][3] = '{
    '{-SEED_S, 0, SEED_L}, '{SEED_S, 0, SEED_L},
    '{-SEED_S, 0, -SEED_L}, '{SEED_S, 0, -SEED_L},
    '{0, SEED_L, SEED_S}, '{0, SEED_L, -SEED_S},
    '{0, -SEED_L, SEED_S}, '{0, -SEED_L, -SEED_S},
    '{SEED_L, SEED_S, 0}, '{-SEED_L, SEED_S, 0},
    '{SEED_L, -SEED_S, 0}, '{-SEED_L, -SEED_S, 0}
  };

  localparam logic [3:0] FACES [20][3] = '{
    '{0, 4, 1}, '{0, 9, 4}, '{9, 5, 4}, '{4, 5, 8}, '{4, 8, 1},
    '{8, 10, 1}, '{8, 3, 10}, '{5, 3, 8}, '{5, 2, 3}, '{2, 7, 3},
    '{7, 10, 3}, '{7, 6, 10}, '{7, 11, 6}, '{11, 0, 6}, '{0, 1, 6},
    '{6, 1, 10}, '{9, 0, 11}, '{9, 11, 2}, '{9, 2, 5}, '{7, 2, 11}
  };

  localparam int ATAN [CORDIC_STEPS] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163
  };

  // midpoint m joins corners PA[m] and PB[m]: ab, ac, bc
  localparam int PA [3] = '{0, 0, 1};
  localparam int PB [3] = '{1, 2, 2};

  typedef struct packed {
    logic err;
    logic [2:0] lvl;
    logic [14:0] idx;
    logic act;
    logic [1:0] dig;
    vec_t [2:0] v;
    logic [2:0][2:0] neg;
    logic [2:0][2:0][16:0] mag;
    logic [2:0][35:0] rad;
    logic [2:0][35:0] root;
    logic [2:0][2:0][32:0] rem;
    logic [2:0][2:0][QBITS-1:0] quo;
  } mid_t;

  typedef struct packed {
    logic err;
    logic [14:0] idx;
    vec_t [2:0] v;
    logic [2:0] zero;
    logic [2:0][33:0] xs;
    logic [2:0][33:0] zs;
    logic [2:0][27:0] acc;
  } cor_t;

endpackage
`default_nettype wire

// File: hdl/ico_mid_cell.sv
`default_nettype none
module ico_mid_cell #(
  parameter int LEVEL = 0,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  ico_pkg::mid_t in_data,
  output logic          out_valid,
  output ico_pkg::mid_t out_data
);
  import ico_pkg::*;

  mid_t nxt;

  generate
    if (STEP == ST_MAG) begin : g_mag
      // corner sums, split into sign and magnitude; pick this level's digit
      always_comb begin : c_mag
        logic [2:0] dsh;
        logic signed [17:0] s;
        nxt = in_data;
        nxt.act = in_data.lvl > 3'(LEVEL);
        dsh = in_data.lvl - 3'(LEVEL) - 3'd1;
        nxt.dig = 2'(in_data.idx >> {dsh, 1'b0});
        for (int m = 0; m < 3; m++) begin
          for (int j = 0; j < 3; j++) begin
            s = 18'($signed(in_data.v[PA[m]][j])) + 18'($signed(in_data.v[PB[m]][j]));
            nxt.neg[m][j] = s[17];
            nxt.mag[m][j] = s[17] ? 17'(-s) : s[16:0];
          end
        end
      end
    end else if (STEP == ST_SQR) begin : g_sqr
      always_comb begin : c_sqr
        logic [33:0] p0, p1, p2;
        nxt = in_data;
        for (int m = 0; m < 3; m++) begin
          p0 = 34'(in_data.mag[m][0]) * 34'(in_data.mag[m][0]);
          p1 = 34'(in_data.mag[m][1]) * 34'(in_data.mag[m][1]);
          p2 = 34'(in_data.mag[m][2]) * 34'(in_data.mag[m][2]);
          nxt.rad[m] = 36'(p0) + 36'(p1) + 36'(p2);
          nxt.root[m] = '0;
        end
      end
    end else if (STEP < ST_DIVINIT) begin : g_root
      // one result bit of the integer square root
      localparam int K = STEP - ST_ROOT0;
      localparam logic [35:0] BITV = 36'(1) << (34 - 2 * K);
      always_comb begin : c_root
        logic [36:0] trial;
        nxt = in_data;
        for (int m = 0; m < 3; m++) begin
          trial = {1'b0, in_data.root[m]} + {1'b0, BITV};
          if ({1'b0, in_data.rad[m]} >= trial) begin
            nxt.rad[m] = in_data.rad[m] - trial[35:0];
            nxt.root[m] = (in_data.root[m] >> 1) + BITV;
          end else begin
            nxt.root[m] = in_data.root[m] >> 1;
          end
        end
      end
    end else if (STEP == ST_DIVINIT) begin : g_dinit
      always_comb begin : c_dinit
        logic [18:0] n;
        nxt = in_data;
        for (int m = 0; m < 3; m++) begin
          n = in_data.root[m][18:0];
          for (int j = 0; j < 3; j++) begin
            nxt.rem[m][j] = 33'({in_data.mag[m][j], 15'b0}) + 33'(n >> 1);
            nxt.quo[m][j] = '0;
          end
        end
      end
    end else if (STEP < ST_FIN) begin : g_div
      // one quotient bit of the rounded scale-back
      localparam int I = QBITS - 1 - (STEP - ST_DIV0);
      always_comb begin : c_div
        logic [36:0] dv;
        nxt = in_data;
        for (int m = 0; m < 3; m++) begin
          dv = 37'(in_data.root[m][18:0]) << I;
          for (int j = 0; j < 3; j++) begin
            if (37'(in_data.rem[m][j]) >= dv) begin
              nxt.rem[m][j] = in_data.rem[m][j] - dv[32:0];
              nxt.quo[m][j][I] = 1'b1;
            end
          end
        end
      end
    end else begin : g_fin
      // clamp, restore sign and keep the child picked by the digit
      always_comb begin : c_fin
        vec_t [2:0] mp;
        logic [16:0] t;
        nxt = in_data;
        for (int m = 0; m < 3; m++) begin
          for (int j = 0; j < 3; j++) begin
            if (in_data.root[m][18:0] == '0) begin
              t = '0;
            end else if (in_data.quo[m][j] > QBITS'(ONE)) begin
              t = 17'(ONE);
            end else begin
              t = in_data.quo[m][j][16:0];
            end
            mp[m][j] = in_data.neg[m][j] ? -t : t;
          end
        end
        if (in_data.act) begin
          unique case (in_data.dig)
            2'd0: begin
              nxt.v[0] = in_data.v[0]; nxt.v[1] = mp[0]; nxt.v[2] = mp[1];
            end
            2'd1: begin
              nxt.v[0] = in_data.v[1]; nxt.v[1] = mp[2]; nxt.v[2] = mp[0];
            end
            2'd2: begin
              nxt.v[0] = in_data.v[2]; nxt.v[1] = mp[1]; nxt.v[2] = mp[2];
            end
            default: begin
              nxt.v[0] = mp[0]; nxt.v[1] = mp[2]; nxt.v[2] = mp[1];
            end
          endcase
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ico_cordic_cell.sv
`default_nettype none
module ico_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  ico_pkg::cor_t in_data,
  output logic          out_valid,
  output ico_pkg::cor_t out_data
);
  import ico_pkg::*;

  cor_t nxt;

  generate
    if (STEP == 0) begin : g_prep
      // move into the right half plane
      always_comb begin : c_prep
        logic signed [33:0] xw, zw;
        nxt = in_data;
        for (int i = 0; i < 3; i++) begin
          xw = 34'($signed(in_data.v[i][0])) <<< (30 - FRAC);
          zw = 34'($signed(in_data.v[i][2])) <<< (30 - FRAC);
          nxt.zero[i] = (xw == '0) && (zw == '0);
          nxt.acc[i] = '0;
          if (xw < 0) begin
            nxt.acc[i] = (zw >= 0) ? PI_ANG : -PI_ANG;
            xw = -xw;
            zw = -zw;
          end
          nxt.xs[i] = xw;
          nxt.zs[i] = zw;
        end
      end
    end else begin : g_iter
      localparam int I = STEP - 1;
      localparam logic signed [27:0] ANG = 28'(ATAN[I]);
      always_comb begin : c_iter
        logic signed [33:0] xw, zw, dx, dz;
        logic signed [27:0] ac;
        nxt = in_data;
        for (int i = 0; i < 3; i++) begin
          xw = $signed(in_data.xs[i]);
          zw = $signed(in_data.zs[i]);
          ac = $signed(in_data.acc[i]);
          dx = zw >>> I;
          dz = xw >>> I;
          if (zw >= 0) begin
            nxt.xs[i] = xw + dx;
            nxt.zs[i] = zw - dz;
            nxt.acc[i] = ac + ANG;
          end else begin
            nxt.xs[i] = xw - dx;
            nxt.zs[i] = zw + dz;
            nxt.acc[i] = ac - ANG;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ico_out.sv
`default_nettype none
module ico_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ico_pkg::cor_t in_data,
  output logic          en,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [95:0]   m_tdata,
  output logic          m_tlast,
  output logic          m_tuser
);
  import ico_pkg::*;

  logic buf_valid;
  logic [1:0] beat;
  logic b_err;
  logic [15:0] b_idx3;
  logic [2:0][15:0] b_px, b_py, b_pz, b_u, b_v;

  logic take, last, load;
  logic [2:0][15:0] n_px, n_py, n_pz, n_u, n_v;

  function automatic logic [15:0] sat_pos(input logic [CW-1:0] c);
    if ($signed(c) > 17'sd32767) return 16'h7fff;
    return c[15:0];
  endfunction

  function automatic logic [15:0] sat_v(input logic signed [17:0] t);
    if (t > 18'sd32767) return 16'h7fff;
    if (t < -18'sd32768) return 16'h8000;
    return t[15:0];
  endfunction

  // round angles, seam fix in corner order, format the three results
  always_comb begin : c_fmt
    logic signed [17:0] tv [3];
    logic signed [27:0] r;
    logic signed [17:0] u;
    for (int i = 0; i < 3; i++) begin
      r = ($signed(in_data.acc[i]) + 28'sd512) >>> 10;
      tv[i] = in_data.zero[i] ? 18'sd0 : 18'(r);
    end
    for (int i = 0; i < 3; i++) begin
      if (tv[i] > V_HIGH) begin
        for (int j = 0; j < 3; j++) begin
          if (j != i && tv[j] <= V_LOW) begin
            tv[j] = tv[j] + V_TURN;
          end
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      n_px[i] = sat_pos(in_data.v[i][0]);
      n_py[i] = sat_pos(in_data.v[i][1]);
      n_pz[i] = sat_pos(in_data.v[i][2]);
      u = 18'($signed(in_data.v[i][1])) + 18'sd32768;
      if (u > 18'sd65535) n_u[i] = 16'hffff;
      else if (u < 0) n_u[i] = 16'h0000;
      else n_u[i] = u[15:0];
      n_v[i] = sat_v(tv[i]);
    end
  end

  assign take = m_tvalid && m_tready;
  assign last = b_err || (beat == 2'd2);
  assign en = !buf_valid || (take && last);
  assign load = en && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      beat <= 2'd0;
    end else if (load) begin
      buf_valid <= 1'b1;
      beat <= 2'd0;
    end else if (take) begin
      if (last) begin
        buf_valid <= 1'b0;
        beat <= 2'd0;
      end else begin
        beat <= beat + 2'd1;
      end
    end
    if (load) begin
      b_err <= in_data.err;
      b_idx3 <= 16'({in_data.idx, 1'b0}) + 16'(in_data.idx);
      b_px <= n_px;
      b_py <= n_py;
      b_pz <= n_pz;
      b_u <= n_u;
      b_v <= n_v;
    end
  end

  assign m_tvalid = buf_valid;
  assign m_tlast = last;
  assign m_tuser = b_err;
  assign m_tdata = b_err ? '0 :
    {b_v[beat], b_u[beat], b_pz[beat], b_py[beat], b_px[beat], b_idx3 + 16'(beat)};

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast) else $error("error request not single");
  a_beats_follow: assert property (@(posedge clk) disable iff (rst)
    take && !m_tlast |=> m_tvalid) else $error("corner request missing");
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    take && !m_tlast |=> m_tdata[15:0] == $past(m_tdata[15:0]) + 16'd1)
    else $error("vertex index not consecutive");
  a_empty_moves: assert property (@(posedge clk) disable iff (rst)
    !buf_valid |-> en) else $error("chain stalled with empty buffer");

endmodule
`default_nettype wire

// File: hdl/icosphere_triangle_generator_core.sv
`default_nettype none
// Icosphere leaf triangle generator. Each input request names one leaf triangle
// (s_tdata[14:0]) of an icosahedron split subdivision_level times (register at
// byte address 0, levels above MAX_LEVEL act as MAX_LEVEL); the core returns
// three corner requests on the m_ side, each with its vertex slot 3*index+k,
// the Q1.15 position (also the normal) and u/v texture coordinates with the
// seam fix across the triangle. An index at or beyond 20*4^level gives a
// single request with m_tuser set and all data zero. The datapath is a row
// of cells: one input register, 40 cells per subdivision level (sum, square,
// 18 square-root bits, divider setup, 18 divider bits, select), 17 CORDIC
// cells, then the output buffer. A new index is taken every cycle while the
// output keeps up; the output port carries one corner per cycle while
// m_tready is high, so a steady stream is paced by the three corners of each
// index (one request for out-of-range indices). The whole row holds when the
// output buffer is still draining.
module icosphere_triangle_generator_core #(
  parameter int MAX_LEVEL = 5
) (
  input  logic        clk,
  input  logic        rst,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // triangle index requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [14:0] triangle_index
  // corner requests
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v
  output logic        m_tlast,   // last_vertex
  output logic        m_tuser    // index_error
);
  import ico_pkg::*;

  localparam int NMID = MAX_LEVEL * STEPS_PER_LEVEL;

  logic [2:0] level_reg;
  logic en;

  // register port: only the level register exists
  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg <= 3'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LEVEL[0]) begin
      level_reg <= pwdata[2:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LEVEL[0]) ? {29'b0, level_reg} : 32'b0;

  // input cell: range check, base face and its corners
  mid_t in_cell;
  always_comb begin : c_in
    logic [2:0] lvl;
    logic [14:0] idx;
    logic [16:0] lim;
    logic [4:0] face;
    in_cell = '0;
    lvl = (level_reg > 3'(MAX_LEVEL)) ? 3'(MAX_LEVEL) : level_reg;
    idx = s_tdata[14:0];
    lim = 17'd20 << {lvl, 1'b0};
    face = 5'(idx >> {lvl, 1'b0});
    if (face > 5'd19) face = 5'd19;
    in_cell.err = 17'(idx) >= lim;
    in_cell.lvl = lvl;
    in_cell.idx = idx;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        in_cell.v[i][j] = CW'(SEEDS[FACES[face][i]][j]);
      end
    end
  end

  assign s_tready = en;

  mid_t mid_d [0:NMID];
  logic mid_v [0:NMID];

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_v[0] <= 1'b0;
    end else if (en) begin
      mid_v[0] <= s_tvalid;
    end
    if (en) begin
      mid_d[0] <= in_cell;
    end
  end

  // subdivision levels, one midpoint triple per level
  genvar gl, gs;
  generate
    for (gl = 0; gl < MAX_LEVEL; gl++) begin : g_lvl
      for (gs = 0; gs < STEPS_PER_LEVEL; gs++) begin : g_step
        ico_mid_cell #(.LEVEL(gl), .STEP(gs)) u_cell (
          .clk(clk), .rst(rst), .en(en),
          .in_valid(mid_v[gl * STEPS_PER_LEVEL + gs]),
          .in_data(mid_d[gl * STEPS_PER_LEVEL + gs]),
          .out_valid(mid_v[gl * STEPS_PER_LEVEL + gs + 1]),
          .out_data(mid_d[gl * STEPS_PER_LEVEL + gs + 1])
        );
      end
    end
  endgenerate

  // hand the corners to the angle chain
  cor_t cor_d [0:CORDIC_CELLS];
  logic cor_v [0:CORDIC_CELLS];

  always_comb begin
    cor_d[0] = '0;
    cor_d[0].err = mid_d[NMID].err;
    cor_d[0].idx = mid_d[NMID].idx;
    cor_d[0].v = mid_d[NMID].v;
  end
  assign cor_v[0] = mid_v[NMID];

  genvar gc;
  generate
    for (gc = 0; gc < CORDIC_CELLS; gc++) begin : g_cor
      ico_cordic_cell #(.STEP(gc)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(cor_v[gc]), .in_data(cor_d[gc]),
        .out_valid(cor_v[gc + 1]), .out_data(cor_d[gc + 1])
      );
    end
  endgenerate

  // seam fix and three-corner output buffer
  ico_out u_out (
    .clk(clk), .rst(rst),
    .in_valid(cor_v[CORDIC_CELLS]), .in_data(cor_d[CORDIC_CELLS]),
    .en(en),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

endmodule
`default_nettype wire
